FILE: rtl/updec_pkg.sv
// Shared types, constants and character helpers for the URL percent decoder.
package updec_pkg;

  // Escape introducer and register indexes
  localparam logic [7:0] PctChar     = 8'h25;
  localparam logic       RegRemapFrom = 1'b0;
  localparam logic       RegRemapTo   = 1'b1;

  // What is held between bytes of a string
  typedef enum logic [2:0] {
    HOLD_NONE  = 3'b001,
    HOLD_PCT   = 3'b010,
    HOLD_DIGIT = 3'b100
  } hold_e;

  // 0-9, A-F, a-f
  function automatic logic is_hex(input logic [7:0] c);
    logic dig;
    logic upr;
    logic lwr;
    dig = (c >= 8'h30) && (c <= 8'h39);
    upr = (c >= 8'h41) && (c <= 8'h46);
    lwr = (c >= 8'h61) && (c <= 8'h66);
    return dig || upr || lwr;
  endfunction

  // Nibble value of a hex digit; letters have bit 6 set and low bits 1..6
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = c[6] ? (c[3:0] + 4'd9) : c[3:0];
    return v;
  endfunction

endpackage

FILE: rtl/url_percent_decoder_unit.sv
// URL percent decoder: one byte in per transaction, up to three result bytes out.
//
// Streaming percent decoder. Each input transaction carries one byte and an
// end-of-string flag; "%XY" with two hex digits becomes one decoded byte, any
// other byte passes through, and a pass-through byte equal to remap_from is
// replaced by remap_to. A plain stream runs at one byte per clock while
// out_ready_i is high. A byte that flushes held escape characters produces
// up to three results, and those leave one per cycle from the result shift
// register while out_ready_i is high; the next byte is decoded only as the
// last leaves. Bytes that only extend an escape produce no result. Each byte
// passes the input register, then the result shift register. An input
// register in front of the decode logic takes one more transaction while a result
// waits; once that register is full, in_ready_o stays low until the last waiting
// result leaves. Configuration writes are taken at once and must happen while idle.
module url_percent_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  import updec_pkg::*;

  // Configuration registers
  logic [7:0] remap_from_q;
  logic [7:0] remap_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remap_from_q <= 8'h00;
      remap_to_q   <= 8'h00;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegRemapFrom: remap_from_q <= cfg_wdata_i;
        RegRemapTo:   remap_to_q   <= cfg_wdata_i;
        default:      remap_from_q <= remap_from_q;
      endcase
    end
  end

  function automatic logic [7:0] pass_byte(input logic [7:0] c, input logic [7:0] from,
                                           input logic [7:0] to);
    return (c == from) ? to : c;
  endfunction

  // Input register
  logic       item_vld_q;
  logic [7:0] item_byte_q;
  logic       item_fin_q;
  logic       item_take;
  logic       grp_free;
  logic       in_fire;

  assign in_ready_o = !item_vld_q || item_take;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_fire) begin
      item_vld_q <= 1'b1;
    end else if (item_take) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_byte_q <= in_byte_i;
      item_fin_q  <= is_final_i;
    end
  end

  // Held escape state
  hold_e      hold_q;
  hold_e      hold_d;
  logic [7:0] held_digit_q;
  logic [7:0] held_digit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q       <= HOLD_NONE;
      held_digit_q <= 8'h00;
    end else if (item_take) begin
      hold_q       <= hold_d;
      held_digit_q <= held_digit_d;
    end
  end

  // Decode: prefix of flushed held bytes, then at most one byte of its own
  logic [1:0] np;
  logic       fo;
  logic       fresh_en;
  logic [7:0] fb;
  logic [7:0] pct_p;
  logic [7:0] dig_p;
  logic       b_hex;
  logic [7:0] slot [3];
  logic [1:0] n_res;

  assign b_hex = is_hex(item_byte_q);
  assign pct_p = pass_byte(PctChar, remap_from_q, remap_to_q);
  assign dig_p = pass_byte(held_digit_q, remap_from_q, remap_to_q);

  always_comb begin
    np           = 2'd0;
    fo           = 1'b0;
    fresh_en     = 1'b0;
    fb           = pass_byte(item_byte_q, remap_from_q, remap_to_q);
    hold_d       = hold_q;
    held_digit_d = held_digit_q;
    unique case (hold_q)
      HOLD_PCT: begin
        if (b_hex && !item_fin_q) begin
          hold_d       = HOLD_DIGIT;
          held_digit_d = item_byte_q;
        end else begin
          np       = 2'd1;
          fresh_en = 1'b1;
        end
      end
      HOLD_DIGIT: begin
        if (b_hex) begin
          fo     = 1'b1;
          fb     = {hex_val(held_digit_q), hex_val(item_byte_q)};
          hold_d = HOLD_NONE;
        end else begin
          np       = 2'd2;
          fresh_en = 1'b1;
        end
      end
      default: fresh_en = 1'b1;
    endcase
    // current byte with nothing held
    if (fresh_en) begin
      if ((item_byte_q == PctChar) && !item_fin_q) begin
        hold_d = HOLD_PCT;
      end else begin
        hold_d = HOLD_NONE;
        fo     = 1'b1;
      end
    end
  end

  assign slot[0] = (np == 2'd0) ? fb : pct_p;
  assign slot[1] = (np == 2'd1) ? fb : dig_p;
  assign slot[2] = fb;
  assign n_res   = np + {1'b0, fo};

  // Result shift register: entry 0 is presented, rem_q counts what is left
  logic [7:0] grp_byte_q [3];
  logic [1:0] rem_q;
  logic       grp_fin_q;
  logic       out_fire;

  assign out_fire  = out_valid_o && out_ready_i;
  assign grp_free  = (rem_q == 2'd0) || (out_ready_i && (rem_q == 2'd1));
  assign item_take = item_vld_q && grp_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else if (item_take) begin
      rem_q <= n_res;
    end else if (out_fire) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take) begin
      grp_byte_q[0] <= slot[0];
      grp_byte_q[1] <= slot[1];
      grp_byte_q[2] <= slot[2];
      grp_fin_q     <= item_fin_q;
    end else if (out_fire) begin
      grp_byte_q[0] <= grp_byte_q[1];
      grp_byte_q[1] <= grp_byte_q[2];
    end
  end

  assign out_valid_o  = (rem_q != 2'd0);
  assign out_byte_o   = grp_byte_q[0];
  assign run_last_o   = (rem_q == 2'd1);
  assign string_end_o = run_last_o && grp_fin_q;

  // Checks
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o)
    else $error("string end flagged on a result that is not the last of its transaction");

  a_final_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take && item_fin_q |=> hold_q == HOLD_NONE)
    else $error("escape still held after end of string");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !run_last_o |=> out_valid_o && !in_ready_o || out_valid_o)
    else $error("result burst ended before its last result");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> (rem_q == 2'd0) || (out_fire && run_last_o))
    else $error("new transaction decoded while earlier results remain");

endmodule
